// File: src/bmph_pkg.sv
package bmph_pkg;

	// field widths
	localparam int COL_W   = 3;
	localparam int BAND_W  = 20;
	localparam int SENS_W  = 12;
	localparam int LEVEL_W = 22;
	localparam int HOLD_W  = 5;
	localparam int ROWS_W  = 8;
	localparam int FRAC_W  = 12;
	localparam int ROWO_W  = 6;

	// packed stream widths
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	// default geometry
	localparam int COLUMNS_DEF = 7;
	localparam int ROWS_DEF    = 40;

	// meter dynamics, Q10.12
	localparam int SMOOTH_STEP = 205;
	localparam int PEAK_FALL   = 16;
	localparam int HOLD_STEPS  = 30;

	// knob: divisor index = floor(sens / 200) = (sens * 5243) >> 20 for 12-bit sens
	localparam int KNOB_MULT_W  = 13;
	localparam int KNOB_MULT    = 5243;
	localparam int KNOB_SHIFT   = 20;
	localparam int KNOB_IDX_W   = 5;
	localparam int SENS_RESET   = 1000;
	localparam logic [KNOB_IDX_W-1:0] KNOB_IDX_RESET =
		KNOB_IDX_W'((SENS_RESET * KNOB_MULT) >> KNOB_SHIFT);

	// exact reciprocal of the divisor: q = (band * R) >> 25, R = ceil(2^25 / d)
	localparam int RECIP_W     = 26;
	localparam int RECIP_SHIFT = 25;

	// raw level = floor(q * 4096 / 1250) = (q * RAW_MULT) >> 30, exact for q < 2^20
	localparam int RAW_MULT_W = 32;
	localparam logic [RAW_MULT_W-1:0] RAW_MULT = 32'd3518437209;
	localparam int RAW_SHIFT  = 30;

	// one column's state word
	typedef struct packed {
		logic [HOLD_W-1:0]  hold;
		logic [LEVEL_W-1:0] peak;
		logic [LEVEL_W-1:0] level;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// reciprocal for divisor idx+1
	function automatic logic [RECIP_W-1:0] recip_lut(input logic [KNOB_IDX_W-1:0] idx);
		logic [RECIP_W-1:0] r;
		unique case (idx)
			5'd0:    r = 26'd33554432;
			5'd1:    r = 26'd16777216;
			5'd2:    r = 26'd11184811;
			5'd3:    r = 26'd8388608;
			5'd4:    r = 26'd6710887;
			5'd5:    r = 26'd5592406;
			5'd6:    r = 26'd4793491;
			5'd7:    r = 26'd4194304;
			5'd8:    r = 26'd3728271;
			5'd9:    r = 26'd3355444;
			5'd10:   r = 26'd3050403;
			5'd11:   r = 26'd2796203;
			5'd12:   r = 26'd2581111;
			5'd13:   r = 26'd2396746;
			5'd14:   r = 26'd2236963;
			5'd15:   r = 26'd2097152;
			5'd16:   r = 26'd1973791;
			5'd17:   r = 26'd1864136;
			5'd18:   r = 26'd1766023;
			5'd19:   r = 26'd1677722;
			5'd20:   r = 26'd1597831;
			default: r = 26'd1597831;
		endcase
		return r;
	endfunction

	localparam logic [RECIP_W-1:0] RECIP_RESET = recip_lut(KNOB_IDX_RESET);

endpackage

// File: src/bar_meter_peak_hold.sv
// Bar meter with peak hold. Each input item carries a column and a band magnitude;
// the block returns one result item per input: the smoothed Q10.12 level
// (4096 = full bar), the lit row count capped at ROWS, and the peak marker row
// with its valid flag. The magnitude is divided by floor(sensitivity/200)+1 and
// scaled by 4096/1250, both through exact reciprocal multipliers. One item is
// taken every cycle while the output is not stalled; each item then goes through the
// divide, then the scale to Q10.12 while the state RAM is read, then the
// read-modify-write, then row scaling into the output register. Per-column state
// lives in one RAM with registered read; back-to-back items on the same column are
// served by forwarding the last write. Reset clears the state at once through
// per-column valid bits, so no clearing pass is needed. Columns at or above COLUMNS
// leave the state alone and return zero fields. Write the sensitivity only while idle.
module bar_meter_peak_hold import bmph_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration: sensitivity knob
	input  logic                  cfg_we,
	input  logic [SENS_W-1:0]     cfg_wdata,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // column[2:0], band_value[22:3]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // column_out[2:0], level[24:3],
	                                         // lit_rows[30:25], peak_row[36:31]
	output logic                  m_tuser    // peak_valid[0]
);

	localparam int AW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int PROD_W = LEVEL_W + ROWS_W;
	localparam int ROWQ_W = PROD_W - FRAC_W;
	localparam int PAD_W  = OUT_DATA_W - COL_W - LEVEL_W - 2 * ROWO_W;

	localparam logic [ROWS_W-1:0] ROWS_V  = ROWS_W'(ROWS);
	localparam logic [ROWQ_W-1:0] ROWS_Q  = ROWQ_W'(ROWS);
	localparam logic [ROWQ_W-1:0] ROWS_M1 = ROWQ_W'(ROWS - 1);

	// configuration
	logic [SENS_W+KNOB_MULT_W-1:0] knob_prod;
	logic [KNOB_IDX_W-1:0]         knob_idx;
	logic [RECIP_W-1:0]            recip_q;

	// input skid
	logic              skid_full_q;
	logic [COL_W-1:0]  skid_col_q;
	logic [BAND_W-1:0] skid_band_q;
	logic              front_vld;
	logic [COL_W-1:0]  front_col;
	logic [BAND_W-1:0] front_band;
	logic              adv;

	// pipeline
	logic                         vld_s1, vld_s2, vld_s3, vld_s4;
	logic [COL_W-1:0]             col_s1, col_s2, col_s3, col_s4;
	logic [BAND_W-1:0]            band_s1;
	logic [BAND_W+RECIP_W-1:0]    prod1;
	logic [BAND_W-1:0]            q_s2;
	logic [BAND_W+RAW_MULT_W-1:0] prod2;
	logic [LEVEL_W-1:0]           raw_s3;
	logic                         inr_s2, inr_s3, inr_s4;
	logic [LEVEL_W-1:0]           lvl_s4, pk_s4;

	// state RAM and forwarding
	logic [COLUMNS-1:0] entry_vld_q;
	logic               ent_vld_rd_q;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic               wr_en;
	entry_t             rdata;
	entry_t             cur;
	entry_t             nxt;
	logic               fwd_vld_q;
	logic [COL_W-1:0]   fwd_col_q;
	entry_t             fwd_data_q;

	// row scaling
	logic [PROD_W-1:0] lit_prod, pk_prod;
	logic [ROWQ_W-1:0] lit_full, prow_full, prow_m1;
	logic [ROWO_W-1:0] lit_rows, peak_row;
	logic              peak_valid;

	// output register
	logic               out_vld_q;
	logic [COL_W-1:0]   out_col_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic [ROWO_W-1:0]  out_lit_q;
	logic [ROWO_W-1:0]  out_prow_q;
	logic               out_pvalid_q;

	// sensitivity knob to divisor reciprocal
	assign knob_prod = SENS_W'(cfg_wdata) * KNOB_MULT_W'(KNOB_MULT);
	assign knob_idx  = knob_prod[KNOB_SHIFT +: KNOB_IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_q <= RECIP_RESET;
		end else if (cfg_we) begin
			recip_q <= recip_lut(knob_idx);
		end
	end

	// whole pipeline moves when the output register can take an item
	assign adv        = !out_vld_q || m_tready;
	assign s_tready   = !skid_full_q;
	assign front_vld  = skid_full_q || s_tvalid;
	assign front_col  = skid_full_q ? skid_col_q  : s_tdata[COL_W-1:0];
	assign front_band = skid_full_q ? skid_band_q : s_tdata[COL_W +: BAND_W];

	// skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (adv) begin
			skid_full_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready && !adv) begin
			skid_col_q  <= s_tdata[COL_W-1:0];
			skid_band_q <= s_tdata[COL_W +: BAND_W];
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= front_vld;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			out_vld_q <= vld_s4;
		end
	end

	// divide by the knob setting, then scale to Q10.12
	assign prod1  = BAND_W'(band_s1) * recip_q;
	assign prod2  = q_s2 * RAW_MULT;
	assign inr_s2 = 32'(col_s2) < COLUMNS;

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1  <= front_col;
			band_s1 <= front_band;
			col_s2  <= col_s1;
			q_s2    <= prod1[RECIP_SHIFT +: BAND_W];
			col_s3  <= col_s2;
			inr_s3  <= inr_s2;
			raw_s3  <= prod2[RAW_SHIFT +: LEVEL_W];
			col_s4  <= col_s3;
			inr_s4  <= inr_s3;
			lvl_s4  <= nxt.level;
			pk_s4   <= nxt.peak;
		end
	end

	// state RAM: read as an item enters s3, write back from s3
	assign raddr = AW'(col_s2);
	assign waddr = AW'(col_s3);
	assign wr_en = adv && vld_s3 && inr_s3;

	bmph_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (COLUMNS)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (nxt),
		.re    (adv),
		.raddr (raddr),
		.rdata (rdata)
	);

	// per-column valid bits; unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q  <= '0;
			ent_vld_rd_q <= 1'b0;
			fwd_vld_q    <= 1'b0;
		end else if (adv) begin
			if (wr_en) begin
				entry_vld_q[waddr] <= 1'b1;
			end
			ent_vld_rd_q <= inr_s2 ? entry_vld_q[raddr] : 1'b0;
			fwd_vld_q    <= wr_en;
		end
	end

	// last write, for an item right behind on the same column
	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_col_q  <= col_s3;
			fwd_data_q <= nxt;
		end
	end

	always_comb begin
		if (fwd_vld_q && fwd_col_q == col_s3) begin
			cur = fwd_data_q;
		end else if (ent_vld_rd_q) begin
			cur = rdata;
		end else begin
			cur = '0;
		end
	end

	bmph_update u_update (
		.raw (raw_s3),
		.cur (cur),
		.nxt (nxt)
	);

	// rows from level and peak
	assign lit_prod  = LEVEL_W'(lvl_s4) * ROWS_V;
	assign pk_prod   = LEVEL_W'(pk_s4) * ROWS_V;
	assign lit_full  = lit_prod[FRAC_W +: ROWQ_W];
	assign prow_full = pk_prod[FRAC_W +: ROWQ_W];
	assign prow_m1   = prow_full - ROWQ_W'(1);

	assign lit_rows   = (lit_full > ROWS_Q) ? ROWO_W'(ROWS_Q) : lit_full[ROWO_W-1:0];
	assign peak_valid = prow_full != '0;

	always_comb begin
		if (!peak_valid) begin
			peak_row = '0;
		end else if (prow_m1 > ROWS_M1) begin
			peak_row = ROWO_W'(ROWS_M1);
		end else begin
			peak_row = prow_m1[ROWO_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_col_q    <= col_s4;
			out_level_q  <= inr_s4 ? lvl_s4 : '0;
			out_lit_q    <= inr_s4 ? lit_rows : '0;
			out_prow_q   <= inr_s4 ? peak_row : '0;
			out_pvalid_q <= inr_s4 && peak_valid;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_prow_q, out_lit_q, out_level_q, out_col_q};
	assign m_tuser  = out_pvalid_q;

`ifndef SYNTHESIS
	// only columns that exist are written
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (32'(col_s3) < COLUMNS))
		else $error("state write for a column out of range");

	// written peak never sits below the written level
	a_peak_ge_level: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (nxt.peak >= nxt.level))
		else $error("peak below level");

	// level falls by at most one smoothing step per item
	a_fall_limit: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ({1'b0, cur.level} <= ({1'b0, nxt.level} + (LEVEL_W+1)'(SMOOTH_STEP))))
		else $error("level fell faster than the smoothing step");

	// hold counter stays within its reload value
	a_hold_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (nxt.hold <= HOLD_W'(HOLD_STEPS)))
		else $error("hold count out of range");

	// the skid only fills while the pipeline is stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !adv) |=> skid_full_q)
		else $error("stalled item not held in skid");
`endif

endmodule

// File: src/bmph_ram.sv
module bmph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/bmph_update.sv
module bmph_update import bmph_pkg::*; (
	input  logic [LEVEL_W-1:0] raw,
	input  entry_t             cur,
	output entry_t             nxt
);

	logic [LEVEL_W:0]   raw_plus;
	logic               drop;
	logic [LEVEL_W-1:0] lvl;
	logic [LEVEL_W-1:0] pk_dec;
	logic [LEVEL_W-1:0] pk0;
	logic [HOLD_W-1:0]  hc0;

	// fall limiter
	assign raw_plus = {1'b0, raw} + (LEVEL_W+1)'(SMOOTH_STEP);
	assign drop     = {1'b0, cur.level} > raw_plus;
	assign lvl      = drop ? cur.level - LEVEL_W'(SMOOTH_STEP) : raw;

	// peak decay once the hold has run out, floored at zero
	assign pk_dec = (cur.peak > LEVEL_W'(PEAK_FALL)) ? cur.peak - LEVEL_W'(PEAK_FALL) : '0;
	assign pk0    = (cur.hold == '0) ? pk_dec : cur.peak;
	assign hc0    = (cur.hold == '0) ? '0 : cur.hold - HOLD_W'(1);

	// a higher level reloads the peak and restarts the hold
	always_comb begin
		nxt.level = lvl;
		if (lvl > pk0) begin
			nxt.peak = lvl;
			nxt.hold = HOLD_W'(HOLD_STEPS);
		end else begin
			nxt.peak = pk0;
			nxt.hold = hc0;
		end
	end

endmodule

// File: dv/bar_meter_peak_hold_tb.sv
`timescale 1ns / 100ps

module bar_meter_peak_hold_tb;
	import bmph_pkg::*;

	localparam int COLUMNS     = COLUMNS_DEF;
	localparam int ROWS        = ROWS_DEF;
	localparam int KNOB_STEP   = 200;
	localparam int FULL_SCALE  = 1250;
	localparam int ONE_Q12     = 1 << FRAC_W;
	localparam longint unsigned LEVEL_MAX = (64'd1 << LEVEL_W) - 1;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LIT_LO      = COL_W + LEVEL_W;
	localparam int PROW_LO     = LIT_LO + ROWO_W;

	typedef struct packed {
		logic [BAND_W-1:0] band;
		logic [COL_W-1:0]  col;
	} band_item_t;

	typedef struct packed {
		logic               pvalid;
		logic [ROWO_W-1:0]  prow;
		logic [ROWO_W-1:0]  lit;
		logic [LEVEL_W-1:0] level;
		logic [COL_W-1:0]   col;
	} meter_reading_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [SENS_W-1:0]     cfg_wdata = SENS_W'(SENS_RESET);
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;   // column[2:0], band_value[22:3]
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;          // column_out[2:0], level[24:3],
	                                         // lit_rows[30:25], peak_row[36:31]
	logic                  m_tuser;          // peak_valid[0]

	bar_meter_peak_hold #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the per-column meter state and the knob
	logic [LEVEL_W-1:0] lvl_mem  [COLUMNS] = '{default: '0};
	logic [LEVEL_W-1:0] pk_mem   [COLUMNS] = '{default: '0};
	logic [HOLD_W-1:0]  hold_mem [COLUMNS] = '{default: '0};
	logic [SENS_W-1:0]  sens_cfg = SENS_W'(SENS_RESET);

	band_item_t     band_q[$];
	meter_reading_t reading_q[$];
	band_item_t     on_bus;

	int n_queued      = 0;
	int n_results     = 0;
	int n_errors      = 0;
	int n_cycles      = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_asks     = 0;
	int hold_granted  = 0;
	int hold_left     = 0;

	function automatic int unsigned rows_of(logic [LEVEL_W-1:0] v);
		return int'((longint'(v) * ROWS) / ONE_Q12);
	endfunction

	// advances one column's meter and returns the reading it should show
	function automatic meter_reading_t meter_reading_for(band_item_t it);
		int unsigned divisor, q, lit, prow;
		longint unsigned raw;
		logic [LEVEL_W-1:0] lvl, last, pk;
		meter_reading_t r;
		r = '0;
		r.col = it.col;
		// out-of-range column: state untouched, fields zero
		if (it.col >= COLUMNS)
			return r;
		divisor = sens_cfg / KNOB_STEP + 1;
		q = it.band / divisor;
		raw = (longint'(q) * ONE_Q12) / FULL_SCALE;
		if (raw > LEVEL_MAX)
			raw = LEVEL_MAX;
		lvl = LEVEL_W'(raw);
		// limit the fall rate
		last = lvl_mem[it.col];
		if (last > lvl && last - lvl > SMOOTH_STEP)
			lvl = LEVEL_W'(last - SMOOTH_STEP);
		lvl_mem[it.col] = lvl;
		// peak: hold, then decay towards zero, reload on a higher level
		pk = pk_mem[it.col];
		if (hold_mem[it.col] == 0)
			pk = (pk > PEAK_FALL) ? LEVEL_W'(pk - PEAK_FALL) : '0;
		else
			hold_mem[it.col] = hold_mem[it.col] - 1'b1;
		if (lvl > pk) begin
			pk = lvl;
			hold_mem[it.col] = HOLD_W'(HOLD_STEPS);
		end
		pk_mem[it.col] = pk;
		lit = rows_of(lvl);
		if (lit > ROWS)
			lit = ROWS;
		prow = rows_of(pk);
		if (prow != 0) begin
			r.pvalid = 1'b1;
			prow = prow - 1;
			if (prow > ROWS - 1)
				prow = ROWS - 1;
			r.prow = ROWO_W'(prow);
		end
		r.level = lvl;
		r.lit   = ROWO_W'(lit);
		return r;
	endfunction

	function automatic void check_field(string name, longint unsigned want,
	                                    longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endfunction

	// sender: presents queued items, predicts each one as it is taken
	always @(posedge clk) begin : sender
		band_item_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				reading_q.push_back(meter_reading_for(on_bus));
			if (!s_tvalid || s_tready) begin
				if (band_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = band_q.pop_front();
					on_bus = nxt;
					s_tdata  <= IN_DATA_W'({nxt.band, nxt.col});
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_granted != hold_asks) begin
			hold_left    <= LONG_HOLD;
			hold_granted <= hold_asks;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver: checks each result item against the oldest prediction
	always @(posedge clk) begin : receiver
		meter_reading_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (reading_q.size() == 0) begin
					$error("unexpected result item, column_out %0d", m_tdata[COL_W-1:0]);
					n_errors++;
				end else begin
					want = reading_q.pop_front();
					check_field("column_out", want.col, m_tdata[COL_W-1:0]);
					check_field("level", want.level, m_tdata[LIT_LO-1:COL_W]);
					check_field("lit_rows", want.lit, m_tdata[PROW_LO-1:LIT_LO]);
					check_field("peak_row", want.prow, m_tdata[PROW_LO+ROWO_W-1:PROW_LO]);
					check_field("peak_valid", want.pvalid, m_tuser);
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("FAIL bar_meter_peak_hold");
			$finish;
		end
	end

	task automatic add_band(logic [COL_W-1:0] col, logic [BAND_W-1:0] band);
		band_item_t it;
		it.col  = col;
		it.band = band;
		band_q.push_back(it);
		n_queued++;
	endtask

	// mostly per-column bursts (a peak then a tail of values no higher, at times long
	// enough for the hold to run out and the peak to decay), the rest loose noise
	task automatic queue_random(int n);
		int left, len;
		logic [COL_W-1:0] col;
		logic [BAND_W-1:0] top;
		left = n;
		while (left > 0) begin
			if ($urandom_range(0, 99) < 15) begin
				add_band(COL_W'($urandom_range(0, 7)), BAND_W'($urandom));
				left--;
			end else begin
				col = COL_W'($urandom_range(0, COLUMNS - 1));
				case ($urandom_range(0, 2))
					0: begin
						top = BAND_W'($urandom);
					end
					1: begin
						top = BAND_W'($urandom_range(0, 40));
					end
					default: begin
						top = BAND_W'($urandom_range(0, 20000));
					end
				endcase
				add_band(col, top);
				left--;
				len = $urandom_range(20, 60);
				while (len > 0 && left > 0) begin
					if ($urandom_range(0, 9) < 6)
						add_band(col, BAND_W'($urandom_range(0, top / 2)));
					else
						add_band(col, BAND_W'($urandom_range(0, top)));
					len--;
					left--;
				end
			end
		end
	endtask

	task automatic wait_drained();
		while (n_results != n_queued)
			@(posedge clk);
	endtask

	// knob write while idle, then a wait for the divisor path to settle
	task automatic set_sensitivity(logic [SENS_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		sens_cfg   = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random(logic [SENS_W-1:0] sens, int n);
		set_sensitivity(sens);
		queue_random(n);
		wait_drained();
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 33;
		recv_idle_pct = 57;

		// directed, reset knob (divisor 6)
		add_band(3'd0, '1);                  // full input, rows capped
		add_band(3'd0, '0);                  // fall limited
		add_band(3'd0, '0);
		add_band(3'd7, '1);                  // column out of range
		add_band(3'd7, '0);
		add_band(3'd1, '0);                  // all zero, peak not valid
		add_band(3'd2, BAND_W'(7500));       // exactly full scale
		add_band(3'd2, BAND_W'(7494));       // small drop, peak held
		add_band(3'd3, BAND_W'(192));        // first lit row
		add_band(3'd3, BAND_W'(186));        // just below first row
		add_band(3'd4, BAND_W'(30));         // tiny peak
		add_band(3'd4, '0);
		add_band(3'd5, BAND_W'(20'hAAAAA));
		add_band(3'd6, BAND_W'(20'h55555));
		add_band(3'd5, BAND_W'(20'h55555));
		add_band(3'd6, BAND_W'(20'hAAAAA));
		add_band(3'd0, '1);                  // full input again while the peak is still held
		wait_drained();

		run_random(12'd0, 250);
		run_random(12'd4095, 250);

		send_idle_pct = 57;
		recv_idle_pct = 33;
		run_random(12'd199, 250);
		run_random(SENS_W'($urandom_range(0, 4095)), 250);

		// no idling; receiver holds off long enough to back the block up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_sensitivity(12'd200);
		hold_asks++;
		queue_random(233);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (reading_q.size() != 0) begin
			$error("%0d predicted result items never arrived", reading_q.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("PASS bar_meter_peak_hold");
		else
			$display("FAIL bar_meter_peak_hold");
		$finish;
	end

endmodule
